>>> hw/rtl/bfsa_pkg.sv
// Package of the best-fit segment allocator: sizes, codes, segment entry,
// sequencer states and the command/status bundles between control and datapath.
// No dependencies.
`timescale 1ns / 1ps

package bfsa_pkg;

  localparam int SEG_DEPTH = 64;
  localparam int IDX_W     = $clog2(SEG_DEPTH);
  localparam int CNT_W     = IDX_W + 1;
  localparam int SZ_W      = 17;
  localparam int HDR_BYTES = 32;
  localparam int ALIGN_W   = 13;
  localparam int POOL_MAX  = 65536;

  localparam logic [SZ_W-1:0] HDR      = SZ_W'(HDR_BYTES);
  localparam logic [SZ_W-1:0] POOL_CAP = SZ_W'(POOL_MAX);

  typedef enum logic [1:0] {
    MODE_ALLOC = 2'd0,
    MODE_FREE  = 2'd1,
    MODE_RESET = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_ZERO    = 3'd1,
    ST_SHORT   = 3'd2,
    ST_NOFIT   = 3'd3,
    ST_BADFREE = 3'd4
  } status_e;

  typedef struct packed {
    logic [SZ_W-1:0] start;
    logic [SZ_W-1:0] size;
    logic            free;
  } seg_t;

  // entry 0 after block reset, pool register at its reset value
  localparam seg_t SEG_RESET = '{start: '0, size: POOL_CAP - HDR, free: 1'b1};

  typedef enum logic [4:0] {
    OP_NONE, OP_INIT_WR, OP_LOAD, OP_READ, OP_EVAL_ALLOC, OP_EVAL_FREE,
    OP_UP_INIT, OP_UP_RD, OP_UP_WR, OP_SPLIT_WR, OP_GRANT_WR,
    OP_MERGE_WR, OP_DN_RD, OP_DN_WR, OP_FREE_FIN, OP_POOL_RST, OP_FINISH
  } dp_op_e;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_CHECK, S_RD, S_EV, S_AEND, S_UP_RD, S_UP_WR,
    S_SPLIT, S_GRANT, S_FEND, S_DN_RD, S_DN_WR, S_FFIN, S_DONE
  } state_e;

  typedef struct packed {
    dp_op_e  op;
    status_e status;
  } dp_cmd_t;

  typedef struct packed {
    mode_e mode;
    logic  zero;
    logic  short_space;
    logic  scan_end;
    logic  found;
    logic  split_ok;
    logic  up_done;
    logic  hit;
    logic  cur_free;
    logic  nxt_done;
    logic  dn_done;
  } dp_sts_t;

  // highest power of two not above the register, zero taken as one
  function automatic logic [ALIGN_W-1:0] eff_align(input logic [ALIGN_W-1:0] a);
    logic [ALIGN_W-1:0] p;
    p = ALIGN_W'(1);
    for (int b = 0; b < ALIGN_W; b++) begin
      if (a[b]) p = ALIGN_W'(1) << b;
    end
    return p;
  endfunction

endpackage

>>> hw/rtl/bfsa_if.sv
// Valid/ready channels of the allocator: request and response.
// Depends on bfsa_pkg, which the request channel imports; field widths are literals.
`timescale 1ns / 1ps

interface bfsa_req_if;
  import bfsa_pkg::*;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [16:0] request_bytes;
  logic [15:0] free_offset;
  modport source (output valid, mode, request_bytes, free_offset, input ready);
  modport sink   (input valid, mode, request_bytes, free_offset, output ready);
endinterface

interface bfsa_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] grant_offset;
  logic [16:0] used_bytes;
  logic [31:0] live_count;
  logic [16:0] peak_bytes;
  logic [31:0] total_allocs;
  logic [31:0] total_frees;
  modport source (output valid, status, grant_offset, used_bytes, live_count,
                  peak_bytes, total_allocs, total_frees, input ready);
  modport sink   (input valid, status, grant_offset, used_bytes, live_count,
                  peak_bytes, total_allocs, total_frees, output ready);
endinterface

>>> hw/rtl/bfsa_datapath.sv
// Datapath: segment table memory, scan/shift registers, statistics, result register.
// Depends on bfsa_pkg; driven one op per cycle by bfsa_ctrl.
`timescale 1ns / 1ps

module bfsa_datapath
  import bfsa_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dp_cmd_t            cmd_i,
  output dp_sts_t            sts_o,
  input  logic [ALIGN_W-1:0] align_i,
  input  logic [SZ_W-1:0]    pool_i,
  input  logic [1:0]         mode_i,
  input  logic [16:0]        request_bytes_i,
  input  logic [15:0]        free_offset_i,
  output logic [2:0]         status_o,
  output logic [15:0]        grant_offset_o,
  output logic [16:0]        used_bytes_o,
  output logic [31:0]        live_count_o,
  output logic [16:0]        peak_bytes_o,
  output logic [31:0]        total_allocs_o,
  output logic [31:0]        total_frees_o
);

  seg_t seg_mem [SEG_DEPTH];
  seg_t rd_q;

  logic [1:0]       mode_q;
  logic [SZ_W-1:0]  req_q;
  logic [15:0]      off_q;
  logic [CNT_W-1:0] idx_q, k_q, count_q;
  logic             found_q, split_q;
  logic [IDX_W-1:0] best_idx_q;
  logic [SZ_W-1:0]  best_size_q, best_start_q;
  logic             hit_q, cur_free_q, prv_q, nxt_q, nxt_done_q, last_free_q;
  logic [CNT_W-1:0] hi_idx_q;
  logic [SZ_W-1:0]  cur_start_q, cur_size_q, prv_start_q, prv_size_q, nxt_size_q;
  logic [SZ_W-1:0]  last_start_q, last_size_q;
  logic [SZ_W-1:0]  used_q, peak_q;
  logic [31:0]      live_q, allocs_q, frees_q;
  logic [15:0]      grant_q;

  logic [2:0]  out_status_q;
  logic [15:0] out_grant_q;
  logic [16:0] out_used_q, out_peak_q;
  logic [31:0] out_live_q, out_allocs_q, out_frees_q;

  // sizing
  logic [ALIGN_W-1:0] amask;
  logic [SZ_W:0]      need, avail;
  logic [SZ_W+1:0]    need_hdr;
  logic [SZ_W-1:0]    pool_eff, pool_seg;
  always_comb begin
    amask    = eff_align(align_i) - ALIGN_W'(1);
    need     = ({1'b0, req_q} + (SZ_W+1)'(amask)) & ~((SZ_W+1)'(amask));
    need_hdr = {1'b0, need} + (SZ_W+2)'(HDR);
    pool_eff = (pool_i > POOL_CAP) ? POOL_CAP : pool_i;
    avail    = (pool_eff > used_q) ? {1'b0, pool_eff - used_q} : '0;
    pool_seg = (pool_eff > HDR) ? pool_eff - HDR : '0;
  end

  // merge geometry for a free
  logic [CNT_W-1:0] m_idx;
  logic [SZ_W-1:0]  m_start, m_size;
  logic [1:0]       r_cnt;
  always_comb begin
    m_idx   = prv_q ? hi_idx_q - CNT_W'(1) : hi_idx_q;
    m_start = prv_q ? prv_start_q : cur_start_q;
    m_size  = cur_size_q + (prv_q ? prv_size_q + HDR : '0)
              + (nxt_q ? nxt_size_q + HDR : '0);
    r_cnt   = 2'(prv_q) + 2'(nxt_q);
  end

  logic [SZ_W-1:0] gsize, used_add;
  logic            a_take, f_match;
  always_comb begin
    gsize    = split_q ? need[SZ_W-1:0] : best_size_q;
    used_add = used_q + gsize;
    a_take   = rd_q.free && ({1'b0, rd_q.size} >= need)
               && (!found_q || rd_q.size < best_size_q);
    f_match  = ({1'b0, rd_q.start} + (SZ_W+1)'(HDR)) == (SZ_W+1)'(off_q);
  end

  // memory port control
  logic             we, re;
  logic [IDX_W-1:0] wa, ra;
  seg_t             wd;
  always_comb begin
    we = 1'b0;
    re = 1'b0;
    wa = '0;
    ra = '0;
    wd = rd_q;
    unique case (cmd_i.op)
      OP_INIT_WR: begin
        we = 1'b1;
        wd = SEG_RESET;
      end
      OP_POOL_RST: begin
        we = 1'b1;
        wd = '{start: '0, size: pool_seg, free: 1'b1};
      end
      OP_READ: begin
        re = 1'b1;
        ra = idx_q[IDX_W-1:0];
      end
      OP_UP_RD: begin
        re = 1'b1;
        ra = IDX_W'(k_q - CNT_W'(1));
      end
      OP_UP_WR, OP_DN_WR: begin
        we = 1'b1;
        wa = k_q[IDX_W-1:0];
      end
      OP_SPLIT_WR: begin
        we = 1'b1;
        wa = best_idx_q + IDX_W'(1);
        wd = '{start: best_start_q + HDR + need[SZ_W-1:0],
               size:  best_size_q - need[SZ_W-1:0] - HDR, free: 1'b1};
      end
      OP_GRANT_WR: begin
        we = 1'b1;
        wa = best_idx_q;
        wd = '{start: best_start_q, size: gsize, free: 1'b0};
      end
      OP_MERGE_WR: begin
        we = 1'b1;
        wa = m_idx[IDX_W-1:0];
        wd = '{start: m_start, size: m_size, free: 1'b1};
      end
      OP_DN_RD: begin
        re = 1'b1;
        ra = IDX_W'(k_q + CNT_W'(r_cnt));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) seg_mem[wa] <= wd;
    if (re) rd_q <= seg_mem[ra];
  end

  // scan and working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        mode_q <= mode_i;
        req_q  <= request_bytes_i;
        off_q  <= free_offset_i;
      end
      OP_EVAL_ALLOC: begin
        if (a_take) begin
          best_idx_q   <= idx_q[IDX_W-1:0];
          best_size_q  <= rd_q.size;
          best_start_q <= rd_q.start;
        end
      end
      OP_EVAL_FREE: begin
        if (!hit_q) begin
          if (f_match) begin
            hi_idx_q    <= idx_q;
            cur_start_q <= rd_q.start;
            cur_size_q  <= rd_q.size;
            prv_start_q <= last_start_q;
            prv_size_q  <= last_size_q;
          end else begin
            last_start_q <= rd_q.start;
            last_size_q  <= rd_q.size;
          end
        end else begin
          nxt_size_q <= rd_q.size;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      k_q         <= '0;
      found_q     <= 1'b0;
      split_q     <= 1'b0;
      hit_q       <= 1'b0;
      cur_free_q  <= 1'b0;
      prv_q       <= 1'b0;
      nxt_q       <= 1'b0;
      nxt_done_q  <= 1'b0;
      last_free_q <= 1'b0;
      count_q     <= CNT_W'(1);
      used_q      <= '0;
      peak_q      <= '0;
      live_q      <= '0;
      allocs_q    <= '0;
      frees_q     <= '0;
      grant_q     <= '0;
    end else begin
      case (cmd_i.op)
        OP_LOAD: begin
          idx_q       <= '0;
          found_q     <= 1'b0;
          split_q     <= 1'b0;
          hit_q       <= 1'b0;
          cur_free_q  <= 1'b0;
          prv_q       <= 1'b0;
          nxt_q       <= 1'b0;
          nxt_done_q  <= 1'b0;
          last_free_q <= 1'b0;
          grant_q     <= '0;
        end
        OP_EVAL_ALLOC: begin
          idx_q <= idx_q + CNT_W'(1);
          if (a_take) found_q <= 1'b1;
        end
        OP_EVAL_FREE: begin
          idx_q <= idx_q + CNT_W'(1);
          if (!hit_q) begin
            if (f_match) begin
              hit_q      <= 1'b1;
              cur_free_q <= rd_q.free;
              prv_q      <= (idx_q != '0) && last_free_q;
            end else begin
              last_free_q <= rd_q.free;
            end
          end else begin
            nxt_q      <= rd_q.free;
            nxt_done_q <= 1'b1;
          end
        end
        OP_UP_INIT: k_q <= count_q;
        OP_UP_WR:   k_q <= k_q - CNT_W'(1);
        OP_SPLIT_WR: begin
          split_q <= 1'b1;
          count_q <= count_q + CNT_W'(1);
        end
        OP_GRANT_WR: begin
          used_q   <= used_add;
          live_q   <= live_q + 32'd1;
          allocs_q <= allocs_q + 32'd1;
          if (used_add > peak_q) peak_q <= used_add;
          grant_q  <= 16'(best_start_q + HDR);
        end
        OP_MERGE_WR: k_q <= m_idx + CNT_W'(1);
        OP_DN_WR:    k_q <= k_q + CNT_W'(1);
        OP_FREE_FIN: begin
          count_q <= count_q - CNT_W'(r_cnt);
          used_q  <= (used_q > cur_size_q) ? used_q - cur_size_q : '0;
          if (live_q != '0) live_q <= live_q - 32'd1;
          frees_q <= frees_q + 32'd1;
        end
        OP_POOL_RST: begin
          count_q <= CNT_W'(1);
          used_q  <= '0;
          live_q  <= '0;
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_FINISH) begin
      out_status_q <= cmd_i.status;
      out_grant_q  <= (cmd_i.status == ST_OK) ? grant_q : '0;
      out_used_q   <= used_q;
      out_live_q   <= live_q;
      out_peak_q   <= peak_q;
      out_allocs_q <= allocs_q;
      out_frees_q  <= frees_q;
    end
  end

  assign status_o       = out_status_q;
  assign grant_offset_o = out_grant_q;
  assign used_bytes_o   = out_used_q;
  assign live_count_o   = out_live_q;
  assign peak_bytes_o   = out_peak_q;
  assign total_allocs_o = out_allocs_q;
  assign total_frees_o  = out_frees_q;

  always_comb begin
    sts_o.mode        = mode_e'(mode_q);
    sts_o.zero        = (req_q == '0);
    sts_o.short_space = (need > avail);
    sts_o.scan_end    = (idx_q == count_q);
    sts_o.found       = found_q;
    sts_o.split_ok    = ({1'b0, best_size_q} >= need_hdr)
                        && (count_q < CNT_W'(SEG_DEPTH));
    sts_o.up_done     = (k_q == CNT_W'(best_idx_q) + CNT_W'(1));
    sts_o.hit         = hit_q;
    sts_o.cur_free    = cur_free_q;
    sts_o.nxt_done    = nxt_done_q;
    sts_o.dn_done     = (r_cnt == '0)
                        || ((CNT_W+1)'(k_q) + (CNT_W+1)'(r_cnt) >= (CNT_W+1)'(count_q));
  end

endmodule

>>> hw/rtl/bfsa_ctrl.sv
// Sequencer of the allocator: walks the table, shifts entries, hands ops to the datapath.
// Depends on bfsa_pkg.
`timescale 1ns / 1ps

module bfsa_ctrl
  import bfsa_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  state_e  state_q, state_d;
  status_e st_q, st_d;
  logic    ovalid_q, ovalid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_INIT;
      st_q     <= ST_OK;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      st_q     <= st_d;
      ovalid_q <= ovalid_d;
    end
  end

  logic is_alloc, scan_stop;
  assign is_alloc  = (sts_i.mode == MODE_ALLOC);
  assign scan_stop = sts_i.scan_end
                     || (!is_alloc && sts_i.hit && (sts_i.cur_free || sts_i.nxt_done));

  always_comb begin
    state_d    = state_q;
    st_d       = st_q;
    ovalid_d   = ovalid_q && !out_ready_i;
    in_ready_o = 1'b0;
    cmd_o.op   = OP_NONE;
    cmd_o.status = st_q;
    unique case (state_q)
      S_INIT: begin
        cmd_o.op = OP_INIT_WR;
        state_d  = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_CHECK;
        end
      end
      S_CHECK: begin
        st_d = ST_OK;
        unique case (sts_i.mode)
          MODE_ALLOC: begin
            if (sts_i.zero) begin
              st_d = ST_ZERO;
              state_d = S_DONE;
            end else if (sts_i.short_space) begin
              st_d = ST_SHORT;
              state_d = S_DONE;
            end else begin
              state_d = S_RD;
            end
          end
          MODE_FREE: state_d = S_RD;
          MODE_RESET: begin
            cmd_o.op = OP_POOL_RST;
            state_d  = S_DONE;
          end
          default: state_d = S_DONE;
        endcase
      end
      S_RD: begin
        if (scan_stop) begin
          state_d = is_alloc ? S_AEND : S_FEND;
        end else begin
          cmd_o.op = OP_READ;
          state_d  = S_EV;
        end
      end
      S_EV: begin
        cmd_o.op = is_alloc ? OP_EVAL_ALLOC : OP_EVAL_FREE;
        state_d  = S_RD;
      end
      S_AEND: begin
        if (!sts_i.found) begin
          st_d = ST_NOFIT;
          state_d = S_DONE;
        end else if (sts_i.split_ok) begin
          cmd_o.op = OP_UP_INIT;
          state_d  = S_UP_RD;
        end else begin
          state_d = S_GRANT;
        end
      end
      S_UP_RD: begin
        if (sts_i.up_done) begin
          state_d = S_SPLIT;
        end else begin
          cmd_o.op = OP_UP_RD;
          state_d  = S_UP_WR;
        end
      end
      S_UP_WR: begin
        cmd_o.op = OP_UP_WR;
        state_d  = S_UP_RD;
      end
      S_SPLIT: begin
        cmd_o.op = OP_SPLIT_WR;
        state_d  = S_GRANT;
      end
      S_GRANT: begin
        cmd_o.op = OP_GRANT_WR;
        st_d     = ST_OK;
        state_d  = S_DONE;
      end
      S_FEND: begin
        if (!sts_i.hit || sts_i.cur_free) begin
          st_d = ST_BADFREE;
          state_d = S_DONE;
        end else begin
          cmd_o.op = OP_MERGE_WR;
          state_d  = S_DN_RD;
        end
      end
      S_DN_RD: begin
        if (sts_i.dn_done) begin
          state_d = S_FFIN;
        end else begin
          cmd_o.op = OP_DN_RD;
          state_d  = S_DN_WR;
        end
      end
      S_DN_WR: begin
        cmd_o.op = OP_DN_WR;
        state_d  = S_DN_RD;
      end
      S_FFIN: begin
        cmd_o.op = OP_FREE_FIN;
        st_d     = ST_OK;
        state_d  = S_DONE;
      end
      S_DONE: begin
        // wait for the result slot to drain
        if (!ovalid_q || out_ready_i) begin
          cmd_o.op = OP_FINISH;
          ovalid_d = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_o = ovalid_q;

endmodule

>>> hw/rtl/best_fit_segment_allocator.sv
// Top level of the best-fit segment allocator: APB register file, sequencer, datapath.
// Depends on bfsa_pkg, bfsa_if, bfsa_ctrl and bfsa_datapath.
//
//   channel  dir  kind                 transaction when
//   req_i    in   valid/ready          valid && ready
//   rsp_o    out  valid/ready          valid && ready
//   apb      in   APB write/read       psel && penable && pwrite (pready = 1)
//
// Zero-size, short, pool-reset and unused-mode items do not walk the table. Allocate
// and free walk it through one memory read port, each entry read in S_RD and evaluated
// in S_EV; an allocate reads every segment. A split first moves the entries above the
// best fit up one at a time, and a good free moves entries down one at a time after
// the merge write.
// After reset the sequencer rebuilds entry 0 before the first request is taken.
// A finished result stays in the output register; the next request is taken
// meanwhile and only its final write-back waits for the output to drain.
`timescale 1ns / 1ps

module best_fit_segment_allocator
  import bfsa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  bfsa_req_if.sink    req_i,
  bfsa_rsp_if.source  rsp_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [ALIGN_W-1:0] align_q;
  logic [SZ_W-1:0]    pool_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      align_q <= ALIGN_W'(16);
      pool_q  <= POOL_CAP;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) pool_q <= pwdata[SZ_W-1:0];
      else          align_q <= pwdata[ALIGN_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[2] ? {{(32-SZ_W){1'b0}}, pool_q} : {{(32-ALIGN_W){1'b0}}, align_q};

  dp_cmd_t cmd;
  dp_sts_t sts;

  bfsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bfsa_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .align_i         (align_q),
    .pool_i          (pool_q),
    .mode_i          (req_i.mode),
    .request_bytes_i (req_i.request_bytes),
    .free_offset_i   (req_i.free_offset),
    .status_o        (rsp_o.status),
    .grant_offset_o  (rsp_o.grant_offset),
    .used_bytes_o    (rsp_o.used_bytes),
    .live_count_o    (rsp_o.live_count),
    .peak_bytes_o    (rsp_o.peak_bytes),
    .total_allocs_o  (rsp_o.total_allocs),
    .total_frees_o   (rsp_o.total_frees)
  );

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for best_fit_segment_allocator: it drives the request
// channel and the APB port, and predicts every response against its own table model.
// Depends on bfsa_pkg, bfsa_if and the allocator RTL.
`timescale 1ns / 1ps

module tb_top;
  import bfsa_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 400;
  localparam logic [2:0] REG_ALIGN = 3'd0;
  localparam logic [2:0] REG_POOL  = 3'd4;

  typedef struct {
    status_e     status;
    logic [15:0] grant;
    logic [16:0] used;
    logic [31:0] live;
    logic [16:0] peak;
    logic [31:0] allocs;
    logic [31:0] frees;
  } alloc_rsp_t;

  class alloc_scoreboard;
    int unsigned   align_reg, pool_reg;
    int unsigned   seg_base[SEG_DEPTH];
    int unsigned   seg_len[SEG_DEPTH];
    bit            seg_avail[SEG_DEPTH];
    int unsigned   nsegs, used_sum, peak_sum;
    logic [31:0]   live_n, alloc_n, free_n;
    alloc_rsp_t    expected_q[$];
    int unsigned   granted_q[$];
    int            errors;

    function new();
      align_reg = 16;
      pool_reg  = POOL_MAX;
      peak_sum  = 0;
      alloc_n   = 0;
      free_n    = 0;
      errors    = 0;
      rebuild_pool();
    endfunction

    function int unsigned pool_size();
      return (pool_reg > POOL_MAX) ? POOL_MAX : pool_reg;
    endfunction

    function int unsigned granule();
      int unsigned p;
      p = 1;
      for (int b = 0; b < 13; b++)
        if (align_reg[b] && b <= 12) p = 1 << b;
      return p;
    endfunction

    function void rebuild_pool();
      int unsigned p;
      p = pool_size();
      for (int i = 0; i < SEG_DEPTH; i++) begin
        seg_base[i]  = 0;
        seg_len[i]   = 0;
        seg_avail[i] = 0;
      end
      seg_len[0]   = (p > HDR_BYTES) ? p - HDR_BYTES : 0;
      seg_avail[0] = 1;
      nsegs    = 1;
      used_sum = 0;
      live_n   = 0;
      granted_q.delete();
    endfunction

    function void coalesce();
      int unsigned i;
      i = 0;
      while (i + 1 < nsegs) begin
        if (seg_avail[i] && seg_avail[i+1]) begin
          seg_len[i] += HDR_BYTES + seg_len[i+1];
          for (int k = i + 1; k + 1 < nsegs; k++) begin
            seg_base[k]  = seg_base[k+1];
            seg_len[k]   = seg_len[k+1];
            seg_avail[k] = seg_avail[k+1];
          end
          nsegs--;
          seg_base[nsegs]  = 0;
          seg_len[nsegs]   = 0;
          seg_avail[nsegs] = 0;
        end else begin
          i++;
        end
      end
    endfunction

    function status_e allocate(int unsigned req, output int unsigned grant);
      int unsigned a, need, avail, best;
      bit hit;
      grant = 0;
      hit   = 0;
      best  = 0;
      if (req == 0) return ST_ZERO;
      a = granule();
      need = (req + a - 1) & ~(a - 1);
      avail = (pool_size() > used_sum) ? pool_size() - used_sum : 0;
      if (need > avail) return ST_SHORT;
      for (int i = 0; i < nsegs; i++)
        if (seg_avail[i] && seg_len[i] >= need && (!hit || seg_len[i] < seg_len[best])) begin
          best = i;
          hit  = 1;
        end
      if (!hit) return ST_NOFIT;
      if (seg_len[best] >= need + HDR_BYTES && nsegs < SEG_DEPTH) begin
        for (int k = nsegs; k > best + 1; k--) begin
          seg_base[k]  = seg_base[k-1];
          seg_len[k]   = seg_len[k-1];
          seg_avail[k] = seg_avail[k-1];
        end
        seg_base[best+1]  = seg_base[best] + HDR_BYTES + need;
        seg_len[best+1]   = seg_len[best] - need - HDR_BYTES;
        seg_avail[best+1] = 1;
        seg_len[best]     = need;
        nsegs++;
      end
      seg_avail[best] = 0;
      used_sum = (used_sum + seg_len[best]) & 32'h1FFFF;
      live_n++;
      alloc_n++;
      if (used_sum > peak_sum) peak_sum = used_sum;
      grant = (seg_base[best] + HDR_BYTES) & 32'hFFFF;
      granted_q.push_back(grant);
      return ST_OK;
    endfunction

    function status_e release_seg(int unsigned off);
      int unsigned i;
      for (i = 0; i < nsegs; i++)
        if (seg_base[i] + HDR_BYTES == off) break;
      if (i >= nsegs || seg_avail[i]) return ST_BADFREE;
      seg_avail[i] = 1;
      used_sum = (used_sum > seg_len[i]) ? used_sum - seg_len[i] : 0;
      if (live_n > 0) live_n--;
      free_n++;
      foreach (granted_q[j])
        if (granted_q[j] == off) begin
          granted_q.delete(j);
          break;
        end
      coalesce();
      return ST_OK;
    endfunction

    function void note_item(logic [1:0] mode, logic [16:0] req, logic [15:0] off);
      alloc_rsp_t  r;
      int unsigned g;
      g = 0;
      r.status = ST_OK;
      case (mode)
        MODE_ALLOC: r.status = allocate(req, g);
        MODE_FREE:  r.status = release_seg(off);
        MODE_RESET: rebuild_pool();
        default: ;
      endcase
      r.grant  = (r.status == ST_OK) ? g[15:0] : '0;
      r.used   = used_sum[16:0];
      r.live   = live_n;
      r.peak   = peak_sum[16:0];
      r.allocs = alloc_n;
      r.frees  = free_n;
      expected_q.push_back(r);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t mismatch %s: got 0x%0h expected 0x%0h", $realtime, what, got, want);
      errors++;
    endtask

    task check_result(alloc_rsp_t got);
      alloc_rsp_t e;
      if (expected_q.size() == 0) begin
        report("unexpected response status", got.status, 0);
        return;
      end
      e = expected_q.pop_front();
      if (got.status !== e.status) report("status", got.status, e.status);
      if (got.grant !== e.grant) report("grant_offset", got.grant, e.grant);
      if (got.used !== e.used) report("used_bytes", got.used, e.used);
      if (got.live !== e.live) report("live_count", got.live, e.live);
      if (got.peak !== e.peak) report("peak_bytes", got.peak, e.peak);
      if (got.allocs !== e.allocs) report("total_allocs", got.allocs, e.allocs);
      if (got.frees !== e.frees) report("total_frees", got.frees, e.frees);
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  bfsa_req_if req_ch();
  bfsa_rsp_if rsp_ch();

  best_fit_segment_allocator dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .req_i(req_ch.sink), .rsp_o(rsp_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  alloc_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles   = 0;
  int quiet_cycles  = 0;

  always #2 clk_i = ~clk_i;

  initial begin
    req_ch.valid = 1'b0;
    req_ch.mode = MODE_NONE;
    req_ch.request_bytes = '0;
    req_ch.free_offset = '0;
    rsp_ch.ready = 1'b0;
  end

  // response side: random stalls, plus a long hold-off when asked
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      rsp_ch.ready = 1'b0;
      hold_cycles--;
    end else begin
      rsp_ch.ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    alloc_rsp_t got;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      got.status = status_e'(rsp_ch.status);
      got.grant  = rsp_ch.grant_offset;
      got.used   = rsp_ch.used_bytes;
      got.live   = rsp_ch.live_count;
      got.peak   = rsp_ch.peak_bytes;
      got.allocs = rsp_ch.total_allocs;
      got.frees  = rsp_ch.total_frees;
      sb.check_result(got);
    end
  end

  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (psel && penable)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task apb_write(logic [2:0] addr, logic [31:0] data);
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = data;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    if (addr == REG_ALIGN) sb.align_reg = data[12:0];
    else sb.pool_reg = data[16:0];
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // one request transaction; valid stays high between back-to-back items unless a random idle gap is drawn
  task send_item(mode_e mode, int unsigned req, int unsigned off);
    @(negedge clk_i);
    if ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid = 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk_i);
    end
    req_ch.valid = 1'b1;
    req_ch.mode = mode;
    req_ch.request_bytes = req[16:0];
    req_ch.free_offset = off[15:0];
    do @(posedge clk_i); while (!req_ch.ready);
    sb.note_item(mode, req[16:0], off[15:0]);
  endtask

  task drain();
    @(negedge clk_i);
    req_ch.valid = 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task random_item();
    int unsigned pick, sz;
    pick = $urandom_range(99);
    if (pick < 55) begin
      case ($urandom_range(9))
        0, 1:    sz = $urandom_range(4096, 1);
        2:       sz = (pick & 1) ? $urandom_range(65536, 1) : $urandom_range(131071, 0);
        default: sz = $urandom_range(256, 1);
      endcase
      send_item(MODE_ALLOC, sz, $urandom_range(65535));
    end else if (pick < 88 && sb.granted_q.size() != 0) begin
      send_item(MODE_FREE, $urandom_range(131071),
                sb.granted_q[$urandom_range(sb.granted_q.size() - 1)]);
    end else if (pick < 94) begin
      send_item(MODE_FREE, $urandom_range(131071), $urandom_range(65535));
    end else if (pick < 97) begin
      send_item(MODE_RESET, $urandom_range(131071), $urandom_range(65535));
    end else begin
      send_item(MODE_NONE, $urandom_range(131071), $urandom_range(65535));
    end
  endtask

  initial begin
    int unsigned align_set[6] = '{1, 0, 4096, 3, 8191, 16};
    int unsigned pool_set[6]  = '{65536, 20, 64, 131071, 65536, 1000};

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: field extremes, every mode, each status code
    send_item(MODE_ALLOC, 0, 0);
    send_item(MODE_ALLOC, 1, 65535);
    send_item(MODE_ALLOC, 100, 0);
    send_item(MODE_ALLOC, 65536, 0);
    send_item(MODE_ALLOC, 131071, 0);
    send_item(MODE_FREE, 0, 32);
    send_item(MODE_FREE, 0, 32);
    send_item(MODE_FREE, 0, 0);
    send_item(MODE_FREE, 131071, 65535);
    send_item(MODE_FREE, 0, 40);
    send_item(MODE_ALLOC, 30000, 0);
    send_item(MODE_ALLOC, 20000, 0);
    send_item(MODE_ALLOC, 5000, 0);
    send_item(MODE_FREE, 0, sb.granted_q[sb.granted_q.size() - 2]);
    send_item(MODE_ALLOC, 25000, 0);
    send_item(MODE_NONE, 131071, 65535);
    send_item(MODE_RESET, 0, 0);
    send_item(MODE_ALLOC, 65504, 0);
    send_item(MODE_ALLOC, 1, 0);
    send_item(MODE_FREE, 0, 32);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph / 2)
        0: begin send_idle_pct = 13; recv_idle_pct = 55; end
        1: begin send_idle_pct = 55; recv_idle_pct = 13; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      apb_write(REG_ALIGN, align_set[ph]);
      apb_write(REG_POOL, pool_set[ph]);
      send_item(MODE_RESET, 0, 0);
      if (ph == 4) hold_cycles = 1500;
      repeat (65) random_item();
      drain();
    end

    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
